// ===== src/iau_pkg.sv =====
// Shared types and codes for the interval arithmetic unit.
// No dependencies; every other file but iau_if refers to this package by scoped name.
package iau_pkg;

  // Operation codes carried in func
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_NEG = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Control flags passed from the arithmetic stage to the reduce stage
  typedef struct packed {
    func_t func;
    logic  invalid;   // an operand interval has low above high
    logic  lin_ovf;   // overflow on the add/subtract/negate path
  } ctrl_t;

endpackage

// ===== src/iau_if.sv =====
// Request and result channel interfaces of the interval arithmetic unit.
// Valid/ready handshake; no package dependency.
interface iau_req_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              func;
  logic signed [WIDTH-1:0] a_low;
  logic signed [WIDTH-1:0] a_high;
  logic signed [WIDTH-1:0] b_low;
  logic signed [WIDTH-1:0] b_high;

  modport source (output valid, func, a_low, a_high, b_low, b_high, input ready);
  modport sink   (input valid, func, a_low, a_high, b_low, b_high, output ready);
endinterface

interface iau_res_if #(
  parameter int WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] res_low;
  logic signed [WIDTH-1:0] res_high;
  logic [1:0]              status;

  modport source (output valid, res_low, res_high, status, input ready);
  modport sink   (input valid, res_low, res_high, status, output ready);
endinterface

// ===== src/iau_arith.sv =====
// Arithmetic stage: operand checks, add/subtract/negate with overflow,
// and the four corner products. Depends on iau_pkg.
module iau_arith #(
  parameter int WIDTH = 32
) (
  input  iau_pkg::func_t            func,
  input  logic signed [WIDTH-1:0]   a_low,
  input  logic signed [WIDTH-1:0]   a_high,
  input  logic signed [WIDTH-1:0]   b_low,
  input  logic signed [WIDTH-1:0]   b_high,
  output iau_pkg::ctrl_t            ctrl,
  output logic [WIDTH-1:0]          lin_low,
  output logic [WIDTH-1:0]          lin_high,
  output logic [3:0][2*WIDTH-1:0]   prod
);

  logic signed [WIDTH-1:0] x0, y0, x1, y1;
  logic                    sub;
  logic signed [WIDTH:0]   s0, s1;

  // Operand selection for the linear operations
  always_comb begin
    x0  = a_low;
    y0  = b_low;
    x1  = a_high;
    y1  = b_high;
    sub = 1'b0;
    case (func)
      iau_pkg::FUNC_ADD: begin
        sub = 1'b0;
      end
      iau_pkg::FUNC_SUB: begin
        y0  = b_high;
        y1  = b_low;
        sub = 1'b1;
      end
      iau_pkg::FUNC_NEG: begin
        x0  = '0;
        y0  = a_high;
        x1  = '0;
        y1  = a_low;
        sub = 1'b1;
      end
      default: begin
        sub = 1'b0;
      end
    endcase
  end

  // One extra bit catches two's-complement overflow
  always_comb begin
    if (sub) begin
      s0 = {x0[WIDTH-1], x0} - {y0[WIDTH-1], y0};
      s1 = {x1[WIDTH-1], x1} - {y1[WIDTH-1], y1};
    end else begin
      s0 = {x0[WIDTH-1], x0} + {y0[WIDTH-1], y0};
      s1 = {x1[WIDTH-1], x1} + {y1[WIDTH-1], y1};
    end
  end

  assign lin_low  = s0[WIDTH-1:0];
  assign lin_high = s1[WIDTH-1:0];

  // Corner products, full 2*WIDTH precision from sign-extended operands
  assign prod[0] = (2*WIDTH)'(a_low)  * (2*WIDTH)'(b_low);
  assign prod[1] = (2*WIDTH)'(a_low)  * (2*WIDTH)'(b_high);
  assign prod[2] = (2*WIDTH)'(a_high) * (2*WIDTH)'(b_low);
  assign prod[3] = (2*WIDTH)'(a_high) * (2*WIDTH)'(b_high);

  // Interval sanity; b is not looked at for negate
  always_comb begin
    ctrl.func    = func;
    ctrl.invalid = (a_high < a_low) || ((func != iau_pkg::FUNC_NEG) && (b_high < b_low));
    ctrl.lin_ovf = (s0[WIDTH] != s0[WIDTH-1]) || (s1[WIDTH] != s1[WIDTH-1]);
  end

endmodule

// ===== src/iau_reduce.sv =====
// Reduce stage: min/max of corner products, product overflow, status
// and zeroing of bounds on error. Depends on iau_pkg.
module iau_reduce #(
  parameter int WIDTH = 32
) (
  input  iau_pkg::ctrl_t           ctrl,
  input  logic [WIDTH-1:0]         lin_low,
  input  logic [WIDTH-1:0]         lin_high,
  input  logic [3:0][2*WIDTH-1:0]  prod,
  output logic [WIDTH-1:0]         res_low,
  output logic [WIDTH-1:0]         res_high,
  output iau_pkg::status_t         status
);

  logic [3:0]              fits;
  logic signed [2*WIDTH-1:0] mn01, mn23, mx01, mx23, mn, mx;
  logic                    ovf;
  logic [WIDTH-1:0]        lo, hi;

  // A product fits when its upper half is a sign extension of bit WIDTH-1
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fits[i] = (prod[i][2*WIDTH-1:WIDTH-1] == '0) || (prod[i][2*WIDTH-1:WIDTH-1] == '1);
    end
  end

  // Two-level min/max tree over the corners
  always_comb begin
    mn01 = ($signed(prod[1]) < $signed(prod[0])) ? $signed(prod[1]) : $signed(prod[0]);
    mn23 = ($signed(prod[3]) < $signed(prod[2])) ? $signed(prod[3]) : $signed(prod[2]);
    mx01 = ($signed(prod[1]) > $signed(prod[0])) ? $signed(prod[1]) : $signed(prod[0]);
    mx23 = ($signed(prod[3]) > $signed(prod[2])) ? $signed(prod[3]) : $signed(prod[2]);
    mn   = (mn23 < mn01) ? mn23 : mn01;
    mx   = (mx23 > mx01) ? mx23 : mx01;
  end

  // Pick path, then apply status
  always_comb begin
    if (ctrl.func == iau_pkg::FUNC_MUL) begin
      ovf = !(&fits);
      lo  = mn[WIDTH-1:0];
      hi  = mx[WIDTH-1:0];
    end else begin
      ovf = ctrl.lin_ovf;
      lo  = lin_low;
      hi  = lin_high;
    end
    if (ctrl.invalid) begin
      status   = iau_pkg::ST_INVALID;
      res_low  = '0;
      res_high = '0;
    end else if (ovf) begin
      status   = iau_pkg::ST_OVERFLOW;
      res_low  = '0;
      res_high = '0;
    end else begin
      status   = iau_pkg::ST_OK;
      res_low  = lo;
      res_high = hi;
    end
  end

endmodule

// ===== src/interval_arithmetic_unit_core.sv =====
// Top level of the interval arithmetic unit: three-register pipeline
// around iau_arith and iau_reduce. Depends on iau_pkg and iau_if.
//
//   channel  | dir | payload                                   | handshake
//   ---------+-----+-------------------------------------------+------------
//   req      | in  | func, a_low, a_high, b_low, b_high        | valid/ready
//   res      | out | res_low, res_high, status                 | valid/ready
//
// One request per cycle is accepted while res is not stalled; each result
// moves through the input, product and result registers in order.
// The corner multipliers set the stage delay between input and product
// registers. Reset (rst, synchronous) empties all three stages.
// A stalled result holds its stage; earlier stages keep filling until
// full, and req.ready drops only when every stage holds a request.
module interval_arithmetic_unit_core #(
  parameter int WIDTH = 32
) (
  input logic     clk,
  input logic     rst,
  iau_req_if.sink   req,
  iau_res_if.source res
);

  // Stage 1: input register
  logic                    s1_valid;
  iau_pkg::func_t          s1_func;
  logic signed [WIDTH-1:0] s1_a_low, s1_a_high, s1_b_low, s1_b_high;

  // Stage 2: arithmetic register
  logic                    s2_valid;
  iau_pkg::ctrl_t          s2_ctrl;
  logic [WIDTH-1:0]        s2_lin_low, s2_lin_high;
  logic [3:0][2*WIDTH-1:0] s2_prod;

  // Arithmetic outputs
  iau_pkg::ctrl_t          ar_ctrl;
  logic [WIDTH-1:0]        ar_lin_low, ar_lin_high;
  logic [3:0][2*WIDTH-1:0] ar_prod;

  // Reduce outputs
  logic [WIDTH-1:0]        rd_low, rd_high;
  iau_pkg::status_t        rd_status;

  // Stage 3: result register
  logic                    s3_valid;
  logic [WIDTH-1:0]        s3_low, s3_high;
  iau_pkg::status_t        s3_status;

  logic adv1, adv2, adv3;

  // A stage may load when empty or when it moves on this cycle
  assign adv3 = !s3_valid || res.ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign req.ready    = adv1;
  assign res.valid    = s3_valid;
  assign res.res_low  = s3_low;
  assign res.res_high = s3_high;
  assign res.status   = s3_status;

  iau_arith #(.WIDTH(WIDTH)) u_arith (
    .func     (s1_func),
    .a_low    (s1_a_low),
    .a_high   (s1_a_high),
    .b_low    (s1_b_low),
    .b_high   (s1_b_high),
    .ctrl     (ar_ctrl),
    .lin_low  (ar_lin_low),
    .lin_high (ar_lin_high),
    .prod     (ar_prod)
  );

  iau_reduce #(.WIDTH(WIDTH)) u_reduce (
    .ctrl     (s2_ctrl),
    .lin_low  (s2_lin_low),
    .lin_high (s2_lin_high),
    .prod     (s2_prod),
    .res_low  (rd_low),
    .res_high (rd_high),
    .status   (rd_status)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= req.valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv1 && req.valid) begin
      s1_func   <= iau_pkg::func_t'(req.func);
      s1_a_low  <= req.a_low;
      s1_a_high <= req.a_high;
      s1_b_low  <= req.b_low;
      s1_b_high <= req.b_high;
    end
    if (adv2 && s1_valid) begin
      s2_ctrl     <= ar_ctrl;
      s2_lin_low  <= ar_lin_low;
      s2_lin_high <= ar_lin_high;
      s2_prod     <= ar_prod;
    end
    if (adv3 && s2_valid) begin
      s3_low    <= rd_low;
      s3_high   <= rd_high;
      s3_status <= rd_status;
    end
  end

endmodule

// ===== src/iau_checker.sv =====
// Port-level checker for interval_arithmetic_unit_core, bound to the top.
// Depends on iau_pkg for status codes.
module iau_checker #(
  parameter int WIDTH = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [WIDTH-1:0] res_low,
  input logic [WIDTH-1:0] res_high,
  input logic [1:0]       status
);

  // A stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_low) && $stable(res_high)
      && $stable(status))
    else $error("result changed while stalled");

  // Error results carry zero bounds
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status != iau_pkg::ST_OK) |-> (res_low == '0) && (res_high == '0))
    else $error("error result with nonzero bounds");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A request accepted while the output flows freely yields a valid result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 res_ready ##1 res_ready |=> res_valid)
    else $error("result missing after request");

endmodule

bind interval_arithmetic_unit_core iau_checker #(.WIDTH(WIDTH)) u_iau_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_low   (res.res_low),
  .res_high  (res.res_high),
  .status    (res.status)
);

// ===== test/tb.sv =====
// Self-checking testbench for interval_arithmetic_unit_core: directed corner cases,
// then random requests with and without valid/ready gaps. Depends on iau_pkg and iau_if
// from src; results are checked against an in-bench interval predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int LIMIT = 500000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct {
    iau_pkg::func_t          op;
    logic signed [W-1:0]     al;
    logic signed [W-1:0]     ah;
    logic signed [W-1:0]     bl;
    logic signed [W-1:0]     bh;
  } iv_req_t;

  typedef struct {
    logic signed [W-1:0]     lo;
    logic signed [W-1:0]     hi;
    iau_pkg::status_t        st;
  } iv_res_t;

  logic clk = 1'b0;
  logic rst;

  iau_req_if #(.WIDTH(W)) req_ch ();
  iau_res_if #(.WIDTH(W)) res_ch ();

  interval_arithmetic_unit_core #(.WIDTH(W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  iv_req_t pending_reqs[$];
  iv_res_t expected_intervals[$];
  int      n_accepted = 0;
  int      n_checked = 0;
  int      errors = 0;
  int      cycles = 0;
  bit      steady = 1'b0;   // no gaps on either side while set
  bit      req_sent = 1'b0;
  int      send_wait = 0;
  int      hold_wait = 0;

  function automatic bit fits_width(longint v);
    return v >= longint'(VMIN) && v <= longint'(VMAX);
  endfunction

  // Expected interval and status for one request
  function automatic iv_res_t interval_result(iv_req_t r);
    longint al, ah, bl, bh, lo, hi;
    longint prod [4];
    iv_res_t res;
    al = r.al;
    ah = r.ah;
    bl = r.bl;
    bh = r.bh;
    lo = 0;
    hi = 0;
    res.st = iau_pkg::ST_OK;
    // invalid operands are flagged before any arithmetic; negate ignores b
    if (ah < al || (r.op != iau_pkg::FUNC_NEG && bh < bl)) begin
      res.st = iau_pkg::ST_INVALID;
    end else begin
      case (r.op)
        iau_pkg::FUNC_ADD: begin
          lo = al + bl;
          hi = ah + bh;
        end
        iau_pkg::FUNC_SUB: begin
          lo = al - bh;
          hi = ah - bl;
        end
        iau_pkg::FUNC_MUL: begin
          prod[0] = al * bl;
          prod[1] = al * bh;
          prod[2] = ah * bl;
          prod[3] = ah * bh;
          lo = prod[0];
          hi = prod[0];
          for (int i = 1; i < 4; i++) begin
            if (prod[i] < lo) lo = prod[i];
            if (prod[i] > hi) hi = prod[i];
          end
        end
        default: begin
          lo = -ah;
          hi = -al;
        end
      endcase
      // a corner product out of range always shows up in the min or the max
      if (!fits_width(lo) || !fits_width(hi)) res.st = iau_pkg::ST_OVERFLOW;
    end
    if (res.st != iau_pkg::ST_OK) begin
      lo = 0;
      hi = 0;
    end
    res.lo = lo[W-1:0];
    res.hi = hi[W-1:0];
    return res;
  endfunction

  // Gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Random bound: full range, small, near the extremes, 16-bit, or shifted
  function automatic logic signed [W-1:0] rand_bound(bit narrow);
    int k;
    k = narrow ? $urandom_range(1, 4) : $urandom_range(0, 4);
    case (k)
      0: return W'($urandom);
      1: return W'(int'($urandom_range(0, 200)) - 100);
      2: return $urandom_range(0, 1) ? VMAX - W'($urandom_range(0, 3))
                                    : VMIN + W'($urandom_range(0, 3));
      3: return W'($signed(16'($urandom)));
      default: return $signed(W'($urandom)) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_request(iau_pkg::func_t op, logic signed [W-1:0] al,
                             logic signed [W-1:0] ah, logic signed [W-1:0] bl,
                             logic signed [W-1:0] bh);
    iv_req_t r;
    r.op = op;
    r.al = al;
    r.ah = ah;
    r.bl = bl;
    r.bh = bh;
    pending_reqs.push_back(r);
  endtask

  // Random request: mostly well-formed intervals, some reversed ones
  task automatic add_random_request();
    iau_pkg::func_t op;
    bit narrow;
    logic signed [W-1:0] x [4];
    op = iau_pkg::func_t'($urandom_range(0, 3));
    narrow = (op == iau_pkg::FUNC_MUL) && ($urandom_range(0, 9) < 7);
    for (int i = 0; i < 4; i++) x[i] = rand_bound(narrow);
    for (int i = 0; i < 4; i += 2) begin
      if ($urandom_range(0, 99) < 92) begin
        if (x[i] > x[i+1]) begin
          x[i]   = x[i] ^ x[i+1];
          x[i+1] = x[i] ^ x[i+1];
          x[i]   = x[i] ^ x[i+1];
        end
      end else if (x[i] < x[i+1]) begin
        x[i]   = x[i] ^ x[i+1];
        x[i+1] = x[i] ^ x[i+1];
        x[i]   = x[i] ^ x[i+1];
      end
    end
    add_request(op, x[0], x[1], x[2], x[3]);
  endtask

  // Block until every queued request has been sent and answered
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || req_ch.valid || n_accepted != n_checked);
  endtask

  // Request driver: new request after acceptance plus a random gap
  always @(negedge clk) begin : drive_req
    iv_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait = 0;
    end else if (!req_ch.valid || req_sent) begin
      if (send_wait > 0) begin
        req_ch.valid <= 1'b0;
        send_wait--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        req_ch.func   <= nxt.op;
        req_ch.a_low  <= nxt.al;
        req_ch.a_high <= nxt.ah;
        req_ch.b_low  <= nxt.bl;
        req_ch.b_high <= nxt.bh;
        req_ch.valid  <= 1'b1;
        send_wait = steady ? 0 : pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_wait = 0;
    end else if (hold_wait > 0) begin
      res_ch.ready <= 1'b0;
      hold_wait--;
    end else begin
      res_ch.ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) hold_wait = pick_gap();
    end
  end

  // Monitor: predict on request acceptance, check on result acceptance
  always @(posedge clk) begin : watch
    iv_req_t seen;
    iv_res_t want;
    req_sent = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_sent = 1'b1;
        seen.op = iau_pkg::func_t'(req_ch.func);
        seen.al = req_ch.a_low;
        seen.ah = req_ch.a_high;
        seen.bl = req_ch.b_low;
        seen.bh = req_ch.b_high;
        expected_intervals.push_back(interval_result(seen));
        n_accepted <= n_accepted + 1;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_intervals.size() == 0) begin
          errors++;
          $display("%0t: unexpected result low=%0d high=%0d status=%0d", $time,
                   res_ch.res_low, res_ch.res_high, res_ch.status);
        end else begin
          want = expected_intervals.pop_front();
          n_checked <= n_checked + 1;
          if (res_ch.res_low !== want.lo || res_ch.res_high !== want.hi ||
              res_ch.status !== want.st) begin
            errors++;
            $display("%0t: mismatch exp lo=%0d hi=%0d st=%0d, got lo=%0d hi=%0d st=%0d",
                     $time, want.lo, want.hi, want.st,
                     res_ch.res_low, res_ch.res_high, res_ch.status);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("interval_arithmetic_unit_core verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid  = 1'b0;
    req_ch.func   = '0;
    req_ch.a_low  = '0;
    req_ch.a_high = '0;
    req_ch.b_low  = '0;
    req_ch.b_high = '0;
    res_ch.ready  = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    add_request(iau_pkg::FUNC_ADD, 1, 2, 3, 4);
    add_request(iau_pkg::FUNC_ADD, 0, VMAX, 0, 1);
    add_request(iau_pkg::FUNC_ADD, VMIN, 0, -1, 0);
    add_request(iau_pkg::FUNC_ADD, VMIN, VMAX, VMIN, VMAX);
    add_request(iau_pkg::FUNC_SUB, 10, 20, -5, 5);
    add_request(iau_pkg::FUNC_SUB, VMIN, 0, 0, 1);
    add_request(iau_pkg::FUNC_SUB, 0, VMAX, -1, 0);
    add_request(iau_pkg::FUNC_SUB, -1, -1, -1, -1);
    add_request(iau_pkg::FUNC_MUL, -3, 5, -7, 2);
    add_request(iau_pkg::FUNC_MUL, 65536, 65536, 65536, 65536);
    add_request(iau_pkg::FUNC_MUL, VMIN, VMIN, -1, -1);
    add_request(iau_pkg::FUNC_MUL, VMIN, VMIN, 1, 1);
    add_request(iau_pkg::FUNC_MUL, -65536, -65536, 32768, 32768);
    add_request(iau_pkg::FUNC_MUL, 46341, 46341, 46341, 46341);
    add_request(iau_pkg::FUNC_MUL, -46340, 46340, -46340, 46340);
    add_request(iau_pkg::FUNC_MUL, VMIN, VMAX, 0, 0);
    add_request(iau_pkg::FUNC_NEG, -5, 7, 0, 0);
    add_request(iau_pkg::FUNC_NEG, VMIN, 0, 0, 0);
    add_request(iau_pkg::FUNC_NEG, VMIN + 1, VMAX, 0, 0);
    // reversed b is ignored by negate
    add_request(iau_pkg::FUNC_NEG, 1, 1, 5, -5);
    // reversed operands
    add_request(iau_pkg::FUNC_ADD, 2, 1, 0, 0);
    add_request(iau_pkg::FUNC_SUB, 0, 0, 1, 0);
    add_request(iau_pkg::FUNC_MUL, VMAX, VMIN, VMAX, VMIN);
    add_request(iau_pkg::FUNC_NEG, VMAX, VMIN, 0, 0);
    wait_drained();

    // random phases: gapped, steady, gapped with a full drain midway, gapped
    for (int phase = 0; phase < 4; phase++) begin
      steady = (phase == 1);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (phase == 2 && n == RANDOM_PER_PHASE / 2) wait_drained();
        add_random_request();
      end
      wait_drained();
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    if (errors == 0 && expected_intervals.size() == 0) begin
      $display("interval_arithmetic_unit_core verification clean");
    end else begin
      $display("interval_arithmetic_unit_core verification failed");
    end
    $finish;
  end

endmodule
